// File: rtl/rte_pkg.sv
// shared types and constants for the round-trip timeout estimator
package rte_pkg;

  localparam int SEQ_WIDTH_DEF     = 16;
  localparam int ELAPSED_WIDTH_DEF = 16;
  localparam int EST_WIDTH         = 20;
  localparam int TIMEOUT_WIDTH     = 19;
  localparam int OP_WIDTH          = 2;
  localparam int OUT_FIELDS_WIDTH  = 2 * EST_WIDTH + TIMEOUT_WIDTH;
  localparam int OUT_TDATA_WIDTH   = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

  localparam logic [EST_WIDTH-1:0] EST_MAX   = {EST_WIDTH{1'b1}};
  localparam logic [EST_WIDTH-1:0] RTT_RESET = EST_WIDTH'(8000);
  localparam logic [EST_WIDTH-1:0] DEV_RESET = EST_WIDTH'(1600);

  typedef enum logic [OP_WIDTH-1:0] {
    OP_TICK    = 2'd0,
    OP_SENT    = 2'd1,
    OP_ACK     = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_t;

  typedef struct packed {
    logic [EST_WIDTH-1:0]     rtt_smoothed;
    logic [EST_WIDTH-1:0]     rtt_deviation;
    logic [TIMEOUT_WIDTH-1:0] timeout_ms;
    logic                     sample_taken;
  } rte_result_t;

endpackage

// File: rtl/rtt_timeout_estimator.sv
// top level: input register, estimator update and result register
// Round-trip timeout estimator. Each input item (tick, segment sent, ack,
// timeout) yields exactly one result item holding the smoothed rtt and
// deviation in sixteenths of a millisecond, the timeout in whole
// milliseconds and a flag for a completed sample. One item is taken every
// cycle while no result waits on m_tready; each item passes through the
// input register, the combinational update and the result register.
// A result that is not taken stalls the input register once it is full.
module rtt_timeout_estimator
  import rte_pkg::*;
#(
  parameter int SEQ_WIDTH     = SEQ_WIDTH_DEF,
  parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SEQ_WIDTH+7)/8)*8-1:0]      s_tdata,  // seq
  input  logic [OP_WIDTH-1:0]                 s_tuser,  // operation
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_TDATA_WIDTH-1:0]          m_tdata,  // rtt_smoothed, rtt_deviation, timeout_ms
  output logic                                m_tuser   // sample_taken
);

  logic                 in_valid;
  op_t                  in_op;
  logic [SEQ_WIDTH-1:0] in_seq;
  logic                 out_valid;
  rte_result_t          out_result;
  rte_result_t          result;
  logic                 advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= op_t'(s_tuser);
      in_seq <= s_tdata[SEQ_WIDTH-1:0];
    end
  end

  rte_track #(
    .SEQ_WIDTH    (SEQ_WIDTH),
    .ELAPSED_WIDTH(ELAPSED_WIDTH)
  ) u_track (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .op    (in_op),
    .seq   (in_seq),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_WIDTH'({out_result.timeout_ms, out_result.rtt_deviation,
                                      out_result.rtt_smoothed});
  assign m_tuser  = out_result.sample_taken;

endmodule

// File: rtl/rte_track.sv
// timing state and smoothed rtt / deviation update for one item per cycle while en is high
module rte_track
  import rte_pkg::*;
#(
  parameter int SEQ_WIDTH     = SEQ_WIDTH_DEF,
  parameter int ELAPSED_WIDTH = ELAPSED_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  op_t                  op,
  input  logic [SEQ_WIDTH-1:0] seq,
  output rte_result_t          result
);

  localparam int SAMPLE_WIDTH = ELAPSED_WIDTH + 4 + EST_WIDTH;
  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = {ELAPSED_WIDTH{1'b1}};

  logic                     timing_active;
  logic [SEQ_WIDTH-1:0]     awaited_seq;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms;
  logic [EST_WIDTH-1:0]     smoothed_rtt;
  logic [EST_WIDTH-1:0]     smoothed_dev;

  logic                     timing_active_next;
  logic [SEQ_WIDTH-1:0]     awaited_seq_next;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms_next;
  logic [EST_WIDTH-1:0]     smoothed_rtt_next;
  logic [EST_WIDTH-1:0]     smoothed_dev_next;
  logic                     sample_taken;

  logic [SAMPLE_WIDTH-1:0]  sample_wide;
  logic [EST_WIDTH-1:0]     sample;
  logic [EST_WIDTH-1:0]     err;
  logic [EST_WIDTH+3:0]     rtt_sum;
  logic [EST_WIDTH+2:0]     dev_sum;
  logic [EST_WIDTH+2:0]     rto_sum;

  // sample in sixteenths, saturated to the estimate range
  always_comb begin
    sample_wide = SAMPLE_WIDTH'(elapsed_ms) << 4;
    sample      = (sample_wide > SAMPLE_WIDTH'(EST_MAX)) ? EST_MAX
                                                         : sample_wide[EST_WIDTH-1:0];
    err         = (smoothed_rtt > sample) ? (smoothed_rtt - sample)
                                          : (sample - smoothed_rtt);
    rtt_sum     = ((EST_WIDTH+4)'(smoothed_rtt) << 3) - (EST_WIDTH+4)'(smoothed_rtt)
                  + (EST_WIDTH+4)'(sample);
    dev_sum     = ((EST_WIDTH+3)'(smoothed_dev) << 1) + (EST_WIDTH+3)'(smoothed_dev)
                  + (EST_WIDTH+3)'(err);
  end

  always_comb begin
    timing_active_next = timing_active;
    awaited_seq_next   = awaited_seq;
    elapsed_ms_next    = elapsed_ms;
    smoothed_rtt_next  = smoothed_rtt;
    smoothed_dev_next  = smoothed_dev;
    sample_taken       = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (timing_active && elapsed_ms != ELAPSED_MAX) begin
          elapsed_ms_next = elapsed_ms + 1'b1;
        end
      end
      OP_SENT: begin
        if (!timing_active) begin
          timing_active_next = 1'b1;
          awaited_seq_next   = seq + 1'b1;
          elapsed_ms_next    = '0;
        end
      end
      OP_ACK: begin
        if (timing_active && seq >= awaited_seq) begin
          timing_active_next = 1'b0;
          if (seq == awaited_seq) begin
            sample_taken      = 1'b1;
            smoothed_rtt_next = rtt_sum[EST_WIDTH+2:3];
            smoothed_dev_next = dev_sum[EST_WIDTH+1:2];
          end
        end
      end
      OP_TIMEOUT: begin
        timing_active_next = 1'b0;
      end
      default: begin
        timing_active_next = timing_active;
      end
    endcase
  end

  always_comb begin
    rto_sum              = (EST_WIDTH+3)'(smoothed_rtt_next)
                           + ((EST_WIDTH+3)'(smoothed_dev_next) << 2);
    result.rtt_smoothed  = smoothed_rtt_next;
    result.rtt_deviation = smoothed_dev_next;
    result.timeout_ms    = rto_sum[EST_WIDTH+2:4];
    result.sample_taken  = sample_taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timing_active <= 1'b0;
      awaited_seq   <= '0;
      elapsed_ms    <= '0;
      smoothed_rtt  <= RTT_RESET;
      smoothed_dev  <= DEV_RESET;
    end else if (en) begin
      timing_active <= timing_active_next;
      awaited_seq   <= awaited_seq_next;
      elapsed_ms    <= elapsed_ms_next;
      smoothed_rtt  <= smoothed_rtt_next;
      smoothed_dev  <= smoothed_dev_next;
    end
  end

  a_sample_needs_timing : assert property (@(posedge clk) disable iff (rst)
    en && sample_taken |-> timing_active)
    else $error("sample taken while not timing");

  a_sample_stops_timing : assert property (@(posedge clk) disable iff (rst)
    en && sample_taken |=> !timing_active)
    else $error("timing still active after sample");

  a_rtt_holds : assert property (@(posedge clk) disable iff (rst)
    en && !sample_taken |=> $stable(smoothed_rtt) && $stable(smoothed_dev))
    else $error("estimates moved without a sample");

  a_sent_starts : assert property (@(posedge clk) disable iff (rst)
    en && op == OP_SENT && !timing_active |=> timing_active && elapsed_ms == '0)
    else $error("sent segment did not start timing");

endmodule
